### rtl/bmp_rgb24_stream_parser_top_assert.svh
// Assertion macros used by the bitmap parser RTL in bmpp_parse.
`ifndef BMP_RGB24_STREAM_PARSER_TOP_ASSERT_SVH
`define BMP_RGB24_STREAM_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BMPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap parser assertion failed");
`define BMPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap parser assertion failed");
`else
`define BMPP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BMPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/bmpp_pkg.sv
package bmpp_pkg;

   localparam int DIM_BITS  = 16;
   localparam int IDX_W     = 16;
   localparam int HDR_POS_W = 6;

   localparam logic [63:0] DIM_MAX_WIDE = (64'd1 << DIM_BITS) - 64'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } bmpp_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_row;
      logic [IDX_W-1:0] pixel_column;
      logic [7:0]       blue_value;
      logic [7:0]       green_value;
      logic [7:0]       red_value;
      logic             last_pixel;
   } bmpp_rsp_type;

   typedef struct packed {
      logic         has_pixel;
      bmpp_rsp_type pixel;
   } bmpp_res_type;

   // Merges one little-endian byte into a dimension and saturates it.
   function automatic logic [DIM_BITS-1:0] put_dim_byte(
      input logic [DIM_BITS-1:0] acc,
      input logic [7:0]          b,
      input logic [1:0]          k
   );
      logic [31:0] wide;
      wide = 32'(acc) | (32'(b) << {k, 3'b000});
      if ({32'd0, wide} > DIM_MAX_WIDE) begin
         return '1;
      end
      return DIM_BITS'(wide);
   endfunction

endpackage

### rtl/bmpp_in_reg.sv
module bmpp_in_reg
   import bmpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bmpp_req_type req_payload,
   input  logic         take,
   output logic         item_valid,
   output bmpp_req_type item
);

   logic         valid_ff;
   logic         valid_in;
   bmpp_req_type item_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/bmpp_parse.sv
module bmpp_parse
   import bmpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  bmpp_req_type item,
   output bmpp_res_type res
);
`include "bmp_rgb24_stream_parser_top_assert.svh"

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXEL  = 2'd1;
   localparam logic [1:0] PH_PAD    = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [HDR_POS_W-1:0] HDR_W_FIRST = 6'd18;
   localparam logic [HDR_POS_W-1:0] HDR_W_LAST  = 6'd21;
   localparam logic [HDR_POS_W-1:0] HDR_H_FIRST = 6'd22;
   localparam logic [HDR_POS_W-1:0] HDR_H_LAST  = 6'd25;
   localparam logic [HDR_POS_W-1:0] HDR_LAST    = 6'd53;

   localparam logic [1:0] COMP_BLUE  = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_RED   = 2'd2;

   logic [HDR_POS_W-1:0] hdr_pos_ff, hdr_pos_in, hdr_pos_cur;
   logic [DIM_BITS-1:0]  width_ff, width_in, width_cur;
   logic [DIM_BITS-1:0]  height_ff, height_in, height_cur;
   logic [DIM_BITS-1:0]  row_ff, row_in, row_cur;
   logic [DIM_BITS-1:0]  col_ff, col_in, col_cur;
   logic [1:0]           comp_ff, comp_in, comp_cur;
   logic [1:0]           pad_ff, pad_in, pad_cur;
   logic [15:0]          held_ff, held_in, held_cur;
   logic [1:0]           phase_ff, phase_in, phase_cur;

   logic                row_end;
   logic                last;
   logic [DIM_BITS-1:0] row_next;
   logic [1:0]          phase_after_row;
   logic [1:0]          pad_dec;

   always_comb begin
      // A start flag restarts parsing before this byte is handled.
      if (item.start_of_file) begin
         hdr_pos_cur = '0;
         width_cur   = '0;
         height_cur  = '0;
         row_cur     = '0;
         col_cur     = '0;
         comp_cur    = COMP_BLUE;
         pad_cur     = '0;
         held_cur    = '0;
         phase_cur   = PH_HEADER;
      end else begin
         hdr_pos_cur = hdr_pos_ff;
         width_cur   = width_ff;
         height_cur  = height_ff;
         row_cur     = row_ff;
         col_cur     = col_ff;
         comp_cur    = comp_ff;
         pad_cur     = pad_ff;
         held_cur    = held_ff;
         phase_cur   = phase_ff;
      end
   end

   assign row_end  = ({1'b0, col_cur} + 1'b1) >= {1'b0, width_cur};
   assign last     = row_end && (({1'b0, row_cur} + 1'b1) >= {1'b0, height_cur});
   assign row_next = row_cur + 1'b1;
   assign phase_after_row = (row_next == '0 || row_next >= height_cur) ? PH_DONE : PH_PIXEL;
   assign pad_dec  = pad_cur - 2'd1;

   always_comb begin
      hdr_pos_in = hdr_pos_cur;
      width_in   = width_cur;
      height_in  = height_cur;
      row_in     = row_cur;
      col_in     = col_cur;
      comp_in    = comp_cur;
      pad_in     = pad_cur;
      held_in    = held_cur;
      phase_in   = phase_cur;

      res.has_pixel          = 1'b0;
      res.pixel.pixel_row    = IDX_W'(row_cur);
      res.pixel.pixel_column = IDX_W'(col_cur);
      res.pixel.blue_value   = held_cur[7:0];
      res.pixel.green_value  = held_cur[15:8];
      res.pixel.red_value    = item.data_byte;
      res.pixel.last_pixel   = last;

      case (phase_cur)
         PH_HEADER: begin
            if (hdr_pos_cur inside {[HDR_W_FIRST:HDR_W_LAST]}) begin
               width_in = put_dim_byte(width_cur, item.data_byte,
                                       2'(hdr_pos_cur - HDR_W_FIRST));
            end else if (hdr_pos_cur inside {[HDR_H_FIRST:HDR_H_LAST]}) begin
               height_in = put_dim_byte(height_cur, item.data_byte,
                                        2'(hdr_pos_cur - HDR_H_FIRST));
            end
            if (hdr_pos_cur >= HDR_LAST) begin
               hdr_pos_in = HDR_LAST;
               row_in     = '0;
               col_in     = '0;
               comp_in    = COMP_BLUE;
               pad_in     = '0;
               phase_in   = (width_cur == '0 || height_cur == '0) ? PH_DONE : PH_PIXEL;
            end else begin
               hdr_pos_in = hdr_pos_cur + 1'b1;
            end
         end
         PH_PIXEL: begin
            case (comp_cur)
               COMP_BLUE: begin
                  held_in = {8'd0, item.data_byte};
                  comp_in = COMP_GREEN;
               end
               COMP_GREEN: begin
                  held_in = {item.data_byte, held_cur[7:0]};
                  comp_in = COMP_RED;
               end
               default: begin
                  res.has_pixel = 1'b1;
                  comp_in       = COMP_BLUE;
                  if (row_end) begin
                     pad_in = width_cur[1:0];
                     if (width_cur[1:0] != 2'd0) begin
                        phase_in = PH_PAD;
                     end else begin
                        col_in   = '0;
                        row_in   = row_next;
                        phase_in = phase_after_row;
                     end
                  end else begin
                     col_in = col_cur + 1'b1;
                  end
               end
            endcase
         end
         PH_PAD: begin
            pad_in = pad_dec;
            if (pad_dec == 2'd0) begin
               col_in   = '0;
               row_in   = row_next;
               phase_in = phase_after_row;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         comp_ff    <= COMP_BLUE;
         pad_ff     <= '0;
         held_ff    <= '0;
         phase_ff   <= PH_HEADER;
      end else if (step) begin
         hdr_pos_ff <= hdr_pos_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         comp_ff    <= comp_in;
         pad_ff     <= pad_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
      end
   end

   `BMPP_ASSERT_NEXT(a_restart, clock, reset, step && item.start_of_file,
      hdr_pos_ff == 6'd1 && phase_ff == PH_HEADER)
   `BMPP_ASSERT_IMP(a_dims_set, clock, reset, phase_ff == PH_PIXEL || phase_ff == PH_PAD,
      width_ff != '0 && height_ff != '0)
   `BMPP_ASSERT_IMP(a_col_range, clock, reset, phase_ff == PH_PIXEL, col_ff < width_ff)
   `BMPP_ASSERT_IMP(a_pad_left, clock, reset, phase_ff == PH_PAD, pad_ff != 2'd0)

endmodule

### rtl/bmpp_out_reg.sv
module bmpp_out_reg
   import bmpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  bmpp_rsp_type pixel,
   output logic         load_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bmpp_rsp_type rsp_payload
);

   logic         valid_ff;
   logic         valid_in;
   bmpp_rsp_type pixel_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = pixel_ff;

endmodule

### rtl/bmp_rgb24_stream_parser_top.sv
// Streaming parser for 24-bit bitmap files.
// The req channel carries one file byte per beat, with a start flag that marks
// byte zero of a new file. The first 54 bytes are header; width and height are
// taken from bytes 18 to 25. Each pixel is three bytes, blue then green then
// red, and rows are padded to a multiple of four bytes.
// The rsp channel carries one beat per pixel with its row, column, colour and
// a flag on the final pixel of the image. Bytes after the image are dropped
// until the next start flag.
// Throughput is one byte per cycle unless a pixel waits on a full output register;
// a red byte passes the input register and then the output register as a pixel beat.
// The input register feeds the parser, which updates its counters in one
// step, and the output register holds the finished pixel.
// Reset empties both registers and expects a header from byte zero.
// When the receiver stalls, header and padding bytes still drain, while a red
// byte waits in the input register and req_ready drops until the output
// register frees up.
module bmp_rgb24_stream_parser_top
   import bmpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bmpp_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bmpp_rsp_type rsp_payload
);

   logic         item_valid;
   bmpp_req_type item;
   bmpp_res_type res;
   logic         load_ready;
   logic         step;

   assign step = item_valid && (!res.has_pixel || load_ready);

   bmpp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .take        (step),
      .item_valid  (item_valid),
      .item        (item)
   );

   bmpp_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .res   (res)
   );

   bmpp_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (step && res.has_pixel),
      .pixel       (res.pixel),
      .load_ready  (load_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
